### sv/psc_pkg.sv
// shared constants and request types of the pair sum counter
package psc_pkg;

  localparam int unsigned MaxItems = 1024;
  localparam int unsigned ValW     = 32;
  localparam int unsigned NeedW    = ValW + 2;
  localparam int unsigned CntW     = 19;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  localparam int unsigned DataW   = 32;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned RegIdxW = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegTarget = RegIdxW'(0);

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_req_t;

  typedef struct packed {
    logic            found;
    logic [CntW-1:0] pair_count;
    logic            overflow;
  } out_req_t;

  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic                    tag;
    logic                    search;
    logic signed [ValW-1:0]  value;
    logic signed [NeedW-1:0] need;
    logic [CntW-1:0]         cnt;
  } tok_t;

endpackage

### sv/psc_cell.sv
// one chain cell: holds one stored value and its running pair total
module psc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  psc_pkg::tok_t  tok_i,
  input  logic [psc_pkg::CntW-1:0] prev_cum_i,
  output psc_pkg::tok_t  tok_o,
  output logic [psc_pkg::CntW-1:0] cum_o
);
  import psc_pkg::*;

  logic                   vld_q, vld_d;
  logic                   tag_q, tag_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [CntW-1:0]        cum_q, cum_d;
  tok_t                   tok_q, tok_d;

  logic            occupied;
  logic            match;
  logic            store;
  logic [CntW:0]   sum;
  logic [CntW-1:0] sat_sum;

  assign occupied = vld_q && (tag_q == tok_i.tag);
  assign match    = (NeedW'(val_q) == tok_i.need);
  assign store    = tok_i.vld && tok_i.search && !occupied;
  assign sum      = {1'b0, prev_cum_i} + {1'b0, tok_i.cnt};
  assign sat_sum  = sum[CntW] ? CountMax : sum[CntW-1:0];

  always_comb begin
    tok_d = tok_i;
    vld_d = vld_q;
    tag_d = tag_q;
    val_d = val_q;
    cum_d = cum_q;
    if (store) begin
      tok_d.search = 1'b0;
      tok_d.cnt    = sat_sum;
      vld_d        = 1'b1;
      tag_d        = tok_i.tag;
      val_d        = tok_i.value;
      cum_d        = sat_sum;
    end else if (tok_i.vld && tok_i.search) begin
      tok_d.cnt = tok_i.cnt + CntW'(match);
    end else if (tok_i.vld) begin
      // a finished request clears stale entries behind its set
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tag_q <= 1'b0;
      val_q <= '0;
      cum_q <= '0;
      tok_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_d;
      tag_q <= tag_d;
      val_q <= val_d;
      cum_q <= cum_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign cum_o = cum_q;

`ifndef NO_ASSERTIONS
  a_store_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && store |=> vld_q && tok_q.vld && !tok_q.search)
    else $error("stored request did not fill the cell");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && tok_i.vld && !tok_i.search |=> !vld_q)
    else $error("finished request did not clear the cell");
`endif

endmodule

### sv/psc_out.sv
// chain exit: gathers per-set flags and holds the result register
module psc_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psc_pkg::tok_t     tok_i,
  input  logic              out_ready_i,
  output logic              adv_o,
  output logic              out_valid_o,
  output psc_pkg::out_req_t out_req_o
);
  import psc_pkg::*;

  logic            out_valid_q, out_valid_d;
  out_req_t        out_req_q, out_req_d;
  logic [CntW-1:0] cum_q, cum_d;
  logic            drop_q, drop_d;
  logic [CntW-1:0] final_cnt;

  assign adv_o     = !out_valid_q || out_ready_i;
  assign final_cnt = tok_i.search ? cum_q : tok_i.cnt;

  always_comb begin
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    cum_d       = cum_q;
    drop_d      = drop_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv_o && tok_i.vld) begin
      if (tok_i.search) begin
        drop_d = 1'b1;
      end else begin
        cum_d = tok_i.cnt;
      end
      if (tok_i.last) begin
        out_valid_d          = 1'b1;
        out_req_d.found      = (final_cnt != '0);
        out_req_d.pair_count = final_cnt;
        out_req_d.overflow   = drop_q || tok_i.search;
        cum_d                = '0;
        drop_d               = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cum_q       <= '0;
      drop_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      cum_q       <= cum_d;
      drop_q      <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

`ifndef NO_ASSERTIONS
  a_set_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && tok_i.vld && tok_i.last |=> !drop_q && cum_q == '0 && out_valid_o)
    else $error("set state not cleared after last request");
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.found == (out_req_o.pair_count != '0))
    else $error("found flag disagrees with pair count");
`endif

endmodule

### sv/pair_sum_counter.sv
// top level: config register, entry stage, cell chain and result stage
//
//  channel   dir  handshake               payload
//  in        in   in_valid_i / in_ready_o  in_req_i  (value, last)
//  out       out  out_valid_o/out_ready_i  out_req_o (found, pair_count, overflow)
//  cfg       in   psel/penable/pwrite      paddr, pwdata, prdata (target_sum)
//
//  one request enters per cycle unless the result stalls; it walks the MaxItems-cell
//  chain one cell a cycle, and the result stage registers the result of its set
//  reset empties every cell and the result stage; no clearing pass is needed
//  a stalled result freezes the whole chain, and in_ready_o drops with it
module pair_sum_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psc_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psc_pkg::out_req_t               out_req_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psc_pkg::PaddrW-1:0]      paddr,
  input  logic [psc_pkg::DataW-1:0]       pwdata,
  output logic [psc_pkg::DataW-1:0]       prdata,
  output logic                            pready
);
  import psc_pkg::*;

  logic signed [ValW-1:0] target_q;
  logic                   set_tag_q;
  tok_t                   in_tok_q, in_tok_d;
  logic                   adv;
  logic                   reg_sel;
  tok_t                   chain_tok [MaxItems+1];
  logic [CntW-1:0]        chain_cum [MaxItems+1];

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1:2] == RegTarget);
  assign prdata  = reg_sel ? DataW'(target_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_q <= pwdata[ValW-1:0];
    end
  end

  assign in_ready_o = adv;

  always_comb begin
    in_tok_d        = in_tok_q;
    in_tok_d.vld    = in_valid_i;
    in_tok_d.last   = in_req_i.last;
    in_tok_d.tag    = set_tag_q;
    in_tok_d.search = 1'b1;
    in_tok_d.value  = in_req_i.value;
    in_tok_d.need   = NeedW'(target_q) - NeedW'(in_req_i.value);
    in_tok_d.cnt    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_tag_q <= 1'b0;
      in_tok_q  <= '0;
    end else if (adv) begin
      in_tok_q <= in_tok_d;
      if (in_valid_i && in_req_i.last) begin
        set_tag_q <= !set_tag_q;
      end
    end
  end

  assign chain_tok[0] = in_tok_q;
  assign chain_cum[0] = '0;

  for (genvar k = 0; k < MaxItems; k++) begin : g_cell
    psc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .tok_i      (chain_tok[k]),
      .prev_cum_i (chain_cum[k]),
      .tok_o      (chain_tok[k+1]),
      .cum_o      (chain_cum[k+1])
    );
  end

  psc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (chain_tok[MaxItems]),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
  a_tag_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last |=> set_tag_q != $past(set_tag_q))
    else $error("set tag did not advance after last request");
`endif

endmodule
